// File: design/ipv6_options_ah_normalizer_macros.svh
// assertion helpers for the normalizer top level
`ifndef IPV6_OPTIONS_AH_NORMALIZER_MACROS_SVH
`define IPV6_OPTIONS_AH_NORMALIZER_MACROS_SVH

// same-cycle implication, held off while reset is low
`define IPV6AHN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define IPV6AHN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ipv6ahn_pkg.sv
package ipv6ahn_pkg;

    // field and datapath widths
    localparam int BYTE_W      = 8;
    localparam int SKIP_W      = 16;
    localparam int JUMBO_W     = 32;
    localparam int LEN_TOTAL_W = 12;

    // one input byte causes at most four output bytes
    localparam int RES_MAX   = 4;
    localparam int RES_IDX_W = 2;

    // option codes
    localparam logic [BYTE_W-1:0] OPT_PAD1        = 8'h00;
    localparam logic [BYTE_W-1:0] OPT_JUMBO       = 8'hC2;
    localparam int                OPT_MUTABLE_BIT = 5;
    localparam logic [BYTE_W-1:0] JUMBO_LEN       = 8'd4;

    // next header and length bytes ahead of the options
    localparam int LEN_PREFIX_BYTES = 2;

    // group of output bytes caused by one input byte, first byte in data[0]
    typedef struct packed {
        logic [RES_MAX-1:0][BYTE_W-1:0] data;
        logic [RES_IDX_W-1:0]           last_idx;
        logic                           hdr_end;
        logic                           ovr;
    } t_grp;

endpackage

// File: design/ipv6ahn_parse.sv
module ipv6ahn_parse #(
    parameter int MAX_HEADER_BYTES = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [ipv6ahn_pkg::BYTE_W-1:0]     i_byte,
    input  logic                               i_start,
    input  logic [ipv6ahn_pkg::BYTE_W-1:0]     i_follow,
    input  logic [ipv6ahn_pkg::SKIP_W-1:0]     i_skip,
    output logic                               o_res_valid,
    output ipv6ahn_pkg::t_grp                  o_grp
);
    import ipv6ahn_pkg::*;

    localparam int HW = $clog2(MAX_HEADER_BYTES + 1);
    localparam int CW = (HW > BYTE_W) ? HW : BYTE_W;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_LEN   = 8'b0000_0010,
        PH_OTYPE = 8'b0000_0100,
        PH_OLEN  = 8'b0000_1000,
        PH_OLENJ = 8'b0001_0000,
        PH_ODATA = 8'b0010_0000,
        PH_JUMBO = 8'b0100_0000,
        PH_RAW   = 8'b1000_0000
    } t_phase;

    t_phase                  r_phase,   n_phase;
    logic [HW-1:0]           r_left,    n_left;
    logic [BYTE_W-1:0]       r_opt_left, n_opt_left;
    logic                    r_mutable, n_mutable;
    logic [1:0]              r_seen,    n_seen;
    logic [JUMBO_W-BYTE_W-1:0] r_jumbo, n_jumbo;

    logic [BYTE_W:0]         w_qwords;
    logic [LEN_TOTAL_W-1:0]  w_total;
    logic [LEN_TOTAL_W-1:0]  w_capped;
    logic [HW-1:0]           w_len_left;
    logic [JUMBO_W-1:0]      w_jumbo_val;
    logic                    w_body;

    // header size from the length byte, cut to the largest header
    assign w_qwords   = {1'b0, i_byte} + (BYTE_W+1)'(1);
    assign w_total    = {w_qwords, 3'b000};
    assign w_capped   = (w_total > LEN_TOTAL_W'(MAX_HEADER_BYTES)) ?
                        LEN_TOTAL_W'(MAX_HEADER_BYTES) : w_total;
    assign w_len_left = HW'(w_capped - LEN_TOTAL_W'(LEN_PREFIX_BYTES));

    // jumbo value less the skipped header bytes, 32-bit wrap
    assign w_jumbo_val = {r_jumbo, i_byte} - JUMBO_W'(i_skip);

    // per-byte parse
    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_opt_left  = r_opt_left;
        n_mutable   = r_mutable;
        n_seen      = r_seen;
        n_jumbo     = r_jumbo;
        w_body      = 1'b0;
        o_res_valid = 1'b0;
        o_grp       = '0;

        if (i_start) begin
            o_res_valid     = 1'b1;
            o_grp.data[0]   = i_follow;
            n_phase         = PH_LEN;
            n_left          = '0;
            n_opt_left      = '0;
            n_mutable       = 1'b0;
            n_seen          = '0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_LEN: begin
                    o_res_valid   = 1'b1;
                    o_grp.data[0] = i_byte;
                    n_left        = w_len_left;
                    if (w_len_left == '0) begin
                        n_phase       = PH_IDLE;
                        o_grp.hdr_end = 1'b1;
                    end else begin
                        n_phase = PH_OTYPE;
                    end
                end
                PH_OTYPE: begin
                    w_body        = 1'b1;
                    o_res_valid   = 1'b1;
                    o_grp.data[0] = i_byte;
                    if (i_byte == OPT_PAD1) begin
                    end else if (r_left <= HW'(1)) begin
                        // type byte is the last header byte
                        o_grp.ovr = 1'b1;
                    end else begin
                        n_mutable = i_byte[OPT_MUTABLE_BIT];
                        n_phase   = (i_byte == OPT_JUMBO && i_skip != '0) ?
                                    PH_OLENJ : PH_OLEN;
                    end
                end
                PH_OLEN, PH_OLENJ: begin
                    w_body        = 1'b1;
                    o_res_valid   = 1'b1;
                    o_grp.data[0] = i_byte;
                    if (CW'(i_byte) > CW'(r_left - HW'(1))) begin
                        // option runs past the header end
                        o_grp.ovr = 1'b1;
                        n_phase   = PH_RAW;
                    end else if (r_phase == PH_OLENJ && i_byte == JUMBO_LEN) begin
                        n_seen  = '0;
                        n_phase = PH_JUMBO;
                    end else begin
                        if (r_phase == PH_OLENJ) begin
                            n_mutable = 1'b0;
                        end
                        n_opt_left = i_byte;
                        n_phase    = (i_byte == '0) ? PH_OTYPE : PH_ODATA;
                    end
                end
                PH_ODATA: begin
                    w_body        = 1'b1;
                    o_res_valid   = 1'b1;
                    o_grp.data[0] = r_mutable ? '0 : i_byte;
                    n_opt_left    = r_opt_left - BYTE_W'(1);
                    if (r_opt_left == BYTE_W'(1)) begin
                        n_phase = PH_OTYPE;
                    end
                end
                PH_JUMBO: begin
                    w_body  = 1'b1;
                    n_jumbo = {r_jumbo[JUMBO_W-2*BYTE_W-1:0], i_byte};
                    if (r_seen == 2'd3) begin
                        o_res_valid    = 1'b1;
                        o_grp.data[0]  = w_jumbo_val[31:24];
                        o_grp.data[1]  = w_jumbo_val[23:16];
                        o_grp.data[2]  = w_jumbo_val[15:8];
                        o_grp.data[3]  = w_jumbo_val[7:0];
                        o_grp.last_idx = RES_IDX_W'(RES_MAX - 1);
                        n_seen         = '0;
                        n_phase        = PH_OTYPE;
                    end else begin
                        n_seen = r_seen + 2'd1;
                    end
                end
                PH_RAW: begin
                    w_body        = 1'b1;
                    o_res_valid   = 1'b1;
                    o_grp.data[0] = i_byte;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // header byte count, end of header returns to idle
            if (w_body) begin
                n_left = r_left - HW'(1);
                if (r_left == HW'(1)) begin
                    n_phase       = PH_IDLE;
                    n_opt_left    = '0;
                    n_seen        = '0;
                    o_grp.hdr_end = o_res_valid;
                end
            end
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_left     <= '0;
            r_opt_left <= '0;
            r_mutable  <= 1'b0;
            r_seen     <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_left     <= n_left;
            r_opt_left <= n_opt_left;
            r_mutable  <= n_mutable;
            r_seen     <= n_seen;
        end
    end

    // jumbo value bytes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_jumbo <= n_jumbo;
        end
    end

endmodule

// File: design/ipv6ahn_ser.sv
module ipv6ahn_ser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  ipv6ahn_pkg::t_grp              i_grp,
    input  logic                           i_out_stall,
    output logic                           o_ready,
    output logic                           o_out_valid,
    output logic [ipv6ahn_pkg::BYTE_W-1:0] o_out_byte,
    output logic                           o_run_end,
    output logic                           o_header_end,
    output logic                           o_overrun
);
    import ipv6ahn_pkg::*;

    logic                 r_valid;
    t_grp                 r_grp;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 w_last;
    logic                 w_take;

    // current byte of the held group
    assign w_last       = (r_idx == r_grp.last_idx);
    assign w_take       = r_valid && !i_out_stall;
    assign o_ready      = !r_valid || (w_take && w_last);
    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_grp.data[r_idx];
    assign o_run_end    = w_last;
    assign o_header_end = w_last && r_grp.hdr_end;
    assign o_overrun    = r_grp.ovr;

    // group occupancy and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

    // group payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

// File: design/ipv6_options_ah_normalizer.sv
// Rewrites an IPv6 hop-by-hop or destination options header, one byte per
// transfer, into the byte stream seen by the AH integrity check: the first
// byte becomes the following header value, mutable option data is zeroed and
// a jumbo payload length has the skipped header length taken off. Each input
// byte gives one output byte, through the input and output group registers,
// and a new byte is taken every cycle while the output is not stalled, except
// in a jumbo payload option: its first three value bytes give no output and
// its fourth gives four, which the single-byte output register sends in turn, holding off input.
// Write skipped_header_length only while no header is in flight.
`include "ipv6_options_ah_normalizer_macros.svh"

module ipv6_options_ah_normalizer #(
    parameter int MAX_HEADER_BYTES = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ipv6ahn_pkg::SKIP_W-1:0] i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ipv6ahn_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                           i_header_start,
    input  logic [ipv6ahn_pkg::BYTE_W-1:0] i_following_header,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ipv6ahn_pkg::BYTE_W-1:0] o_out_byte,
    output logic                           o_run_end,
    output logic                           o_header_end,
    output logic                           o_overrun
);
    import ipv6ahn_pkg::*;

    logic [SKIP_W-1:0] r_skip;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_start;
    logic [BYTE_W-1:0] r_follow;

    logic              w_in_accept;
    logic              w_fire;
    logic              w_ser_ready;
    logic              w_res_valid;
    t_grp              w_grp;

    // input register handshake
    assign o_in_stall  = r_in_valid && !w_ser_ready;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_fire      = r_in_valid && w_ser_ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
        end else if (i_cfg_wr_en) begin
            r_skip <= i_cfg_wr_data;
        end
    end

    // input register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_byte   <= i_in_byte;
            r_start  <= i_header_start;
            r_follow <= i_following_header;
        end
    end

    ipv6ahn_parse #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_fire),
        .i_byte     (r_byte),
        .i_start    (r_start),
        .i_follow   (r_follow),
        .i_skip     (r_skip),
        .o_res_valid(w_res_valid),
        .o_grp      (w_grp)
    );

    ipv6ahn_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire && w_res_valid),
        .i_grp       (w_grp),
        .i_out_stall (i_out_stall),
        .o_ready     (w_ser_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end),
        .o_header_end(o_header_end),
        .o_overrun   (o_overrun)
    );

    // checks
    `IPV6AHN_ASSERT_NOW(a_hdr_end_on_run_end, i_clk, i_rst_n, o_out_valid && o_header_end, o_run_end, "header end not on last byte of a run")
    `IPV6AHN_ASSERT_NOW(a_overrun_single, i_clk, i_rst_n, o_out_valid && o_overrun, o_run_end, "overrun flagged inside a multi-byte run")
    `IPV6AHN_ASSERT_NEXT(a_held_item, i_clk, i_rst_n, r_in_valid && o_in_stall, r_in_valid && $stable(r_byte) && $stable(r_start), "held input item lost or changed")

endmodule
